>>> rtl/rncc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rncc_pkg
// Shared types, constants and helpers for the nearest color classifier.
// ----------------------------------------------------------------------------
package rncc_pkg;

  localparam int CountW    = 24;  // raw counts and calibration registers
  localparam int IntenW    = 8;   // mapped intensity
  localparam int NumW      = 32;  // (black - raw) * 255
  localparam int DenShW    = 31;  // divisor aligned to the top quotient bit
  localparam int DistW     = 18;  // squared distance, max 3 * 255^2
  localparam int SqW       = 16;
  localparam int IdxW      = 3;
  localparam int RegIdxW   = 3;
  localparam int NumRefs   = 5;
  localparam int DivSteps  = 8;   // one quotient bit per stage
  localparam int FrontStg  = 2;
  localparam int NearStg   = 4;
  localparam int NumStages = FrontStg + DivSteps + NearStg;
  localparam int DataInW   = 72;
  localparam int DataOutW  = 32;

  localparam logic [CountW-1:0] WHITE_RED_RST   = 24'd225;
  localparam logic [CountW-1:0] BLACK_RED_RST   = 24'd600;
  localparam logic [CountW-1:0] WHITE_GREEN_RST = 24'd220;
  localparam logic [CountW-1:0] BLACK_GREEN_RST = 24'd800;
  localparam logic [CountW-1:0] WHITE_BLUE_RST  = 24'd240;
  localparam logic [CountW-1:0] BLACK_BLUE_RST  = 24'd750;

  localparam logic [IntenW-1:0] FULL_SCALE = 8'd255;
  localparam logic [IntenW-1:0] ZERO_SCALE = 8'd0;
  localparam logic [DistW-1:0]  DIST_BOUND = 18'd100000;

  typedef enum logic [RegIdxW-1:0] {
    REG_WHITE_RED   = 3'd0,
    REG_BLACK_RED   = 3'd1,
    REG_WHITE_GREEN = 3'd2,
    REG_BLACK_GREEN = 3'd3,
    REG_WHITE_BLUE  = 3'd4,
    REG_BLACK_BLUE  = 3'd5
  } cfg_reg_t;

  typedef enum logic [IdxW-1:0] {
    COLOR_RED   = 3'd0,
    COLOR_GREEN = 3'd1,
    COLOR_BLUE  = 3'd2,
    COLOR_WHITE = 3'd3,
    COLOR_BLACK = 3'd4
  } color_t;

  // Reference colors: every component is either 0 or 255, so one bit per
  // channel says which. Bit 0 red, bit 1 green, bit 2 blue.
  localparam logic [NumRefs-1:0][2:0] REF_FULL = {
    3'b000,  // black
    3'b111,  // white
    3'b100,  // blue
    3'b010,  // green
    3'b001   // red
  };

  // One channel on its way through the divider
  typedef struct packed {
    logic              fixed;      // result known without division
    logic [IntenW-1:0] fixed_val;
    logic [DenShW-1:0] den_sh;
    logic [NumW-1:0]   rem;
    logic [IntenW-1:0] quo;
  } div_chan_t;

  function automatic logic [IntenW-1:0] chan_intensity(input div_chan_t c);
    return c.fixed ? c.fixed_val : c.quo;
  endfunction

endpackage

>>> rtl/rgb_nearest_color_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_nearest_color_classifier_unit
// Maps three raw color counts to intensities and names the nearest color.
// ----------------------------------------------------------------------------
// Usage
//   Input stream (s_axis_*): one reading per transfer, three 24-bit pulse
//   counts. Output stream (m_axis_*): one result per reading, in order: the
//   red, green and blue intensities (0..255) and the nearest reference color
//   (0 red, 1 green, 2 blue, 3 white, 4 black; ties go to the lower code).
//   Calibration: six 24-bit white/black counts written through cfg_we,
//   cfg_index, cfg_data; indexes 6 and 7 are ignored. Write only while idle.
// Timing
//   14 pipeline stages: 2 calibration stages, 8 quotient stages (one bit
//   each of floor((black-raw)*255/(black-white))), 4 distance stages ending
//   in the output register. One reading is taken every cycle unless a
//   stalled output has filled the pipeline.
// Reset
//   rst empties the pipeline and loads the default calibration counts.
// Stall
//   Each stage holds when it is full and the stage after it cannot take its
//   item, so bubbles close up; s_axis_tready drops only once every stage is
//   full behind a stalled output. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rgb_nearest_color_classifier_unit (
  input  logic                          clk,
  input  logic                          rst,
  // raw_red[23:0], raw_green[47:24], raw_blue[71:48]
  input  logic [rncc_pkg::DataInW-1:0]  s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // red[7:0], green[15:8], blue[23:16], color_index[26:24], zero fill
  output logic [rncc_pkg::DataOutW-1:0] m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_we,
  input  logic [rncc_pkg::RegIdxW-1:0]  cfg_index,
  input  logic [rncc_pkg::CountW-1:0]   cfg_data
);
  import rncc_pkg::*;

  // Calibration registers
  logic [CountW-1:0] white_red, black_red;
  logic [CountW-1:0] white_green, black_green;
  logic [CountW-1:0] white_blue, black_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      white_red   <= WHITE_RED_RST;
      black_red   <= BLACK_RED_RST;
      white_green <= WHITE_GREEN_RST;
      black_green <= BLACK_GREEN_RST;
      white_blue  <= WHITE_BLUE_RST;
      black_blue  <= BLACK_BLUE_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WHITE_RED:   white_red   <= cfg_data;
        REG_BLACK_RED:   black_red   <= cfg_data;
        REG_WHITE_GREEN: white_green <= cfg_data;
        REG_BLACK_GREEN: black_green <= cfg_data;
        REG_WHITE_BLUE:  white_blue  <= cfg_data;
        REG_BLACK_BLUE:  black_blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-stage valid bits and advance enables (stage NumStages-1 is output)
  logic [NumStages-1:0] vld;
  logic [NumStages-1:0] adv;
  logic [NumStages-1:0] vld_in;

  always_comb begin
    adv[NumStages-1] = !vld[NumStages-1] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign vld_in = {vld[NumStages-2:0], s_axis_tvalid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (adv[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld[NumStages-1];

  // Channel datapaths: front end then quotient chain
  logic [2:0][CountW-1:0] raw_ch, white_ch, black_ch;
  div_chan_t              chain [3][DivSteps+1];

  assign raw_ch   = {s_axis_tdata[71:48], s_axis_tdata[47:24], s_axis_tdata[23:0]};
  assign white_ch = {white_blue, white_green, white_red};
  assign black_ch = {black_blue, black_green, black_red};

  for (genvar c = 0; c < 3; c++) begin : g_chan
    rncc_front u_front (
      .clk   (clk),
      .en_a  (adv[0]),
      .en_b  (adv[1]),
      .raw   (raw_ch[c]),
      .white (white_ch[c]),
      .black (black_ch[c]),
      .chan  (chain[c][0])
    );
    for (genvar j = 0; j < DivSteps; j++) begin : g_step
      rncc_div_step u_step (
        .clk      (clk),
        .en       (adv[FrontStg+j]),
        .chan_in  (chain[c][j]),
        .chan_out (chain[c][j+1])
      );
    end
  end

  // Nearest reference search and output register
  logic [IntenW-1:0] red, green, blue;
  color_t            color_index;

  rncc_nearest u_nearest (
    .clk         (clk),
    .en          (adv[NumStages-1:FrontStg+DivSteps]),
    .chan_r      (chain[0][DivSteps]),
    .chan_g      (chain[1][DivSteps]),
    .chan_b      (chain[2][DivSteps]),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .color_index (color_index)
  );

  assign m_axis_tdata = {5'd0, color_index, blue, green, red};

endmodule

>>> rtl/rncc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rncc_front
// Two-stage calibration front end for one channel: range checks, numerator
// and aligned divisor for the quotient pipeline.
// ----------------------------------------------------------------------------
module rncc_front (
  input  logic                        clk,
  input  logic                        en_a,
  input  logic                        en_b,
  input  logic [rncc_pkg::CountW-1:0] raw,
  input  logic [rncc_pkg::CountW-1:0] white,
  input  logic [rncc_pkg::CountW-1:0] black,
  output rncc_pkg::div_chan_t         chan
);
  import rncc_pkg::*;

  logic              full;
  logic              zero;
  logic [CountW-1:0] diff;
  logic [CountW-1:0] den;

  // Stage A: white test wins over black test
  always_ff @(posedge clk) begin
    if (en_a) begin
      full <= (raw <= white);
      zero <= (raw >= black);
      diff <= black - raw;
      den  <= black - white;
    end
  end

  // Stage B: diff * 255 = (diff << 8) - diff
  always_ff @(posedge clk) begin
    if (en_b) begin
      chan.fixed     <= full | zero;
      chan.fixed_val <= full ? FULL_SCALE : ZERO_SCALE;
      chan.rem       <= {diff, 8'd0} - {8'd0, diff};
      chan.den_sh    <= {den, 7'd0};
      chan.quo       <= '0;
    end
  end

endmodule

>>> rtl/rncc_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rncc_div_step
// One restoring division step: one quotient bit, divisor shifts down a bit.
// ----------------------------------------------------------------------------
module rncc_div_step (
  input  logic                clk,
  input  logic                en,
  input  rncc_pkg::div_chan_t chan_in,
  output rncc_pkg::div_chan_t chan_out
);
  import rncc_pkg::*;

  logic [NumW-1:0] den_ext;
  logic            take;

  assign den_ext = {1'b0, chan_in.den_sh};
  assign take    = (chan_in.rem >= den_ext);

  always_ff @(posedge clk) begin
    if (en) begin
      chan_out.fixed     <= chan_in.fixed;
      chan_out.fixed_val <= chan_in.fixed_val;
      chan_out.den_sh    <= chan_in.den_sh >> 1;
      chan_out.rem       <= take ? (chan_in.rem - den_ext) : chan_in.rem;
      chan_out.quo       <= {chan_in.quo[IntenW-2:0], take};
    end
  end

endmodule

>>> rtl/rncc_nearest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rncc_nearest
// Four-stage nearest reference search: squares, distance sums, pairwise
// minimum, final pick against the bound. Last stage is the output register.
// ----------------------------------------------------------------------------
module rncc_nearest (
  input  logic                                 clk,
  input  logic [rncc_pkg::NearStg-1:0]         en,
  input  rncc_pkg::div_chan_t                  chan_r,
  input  rncc_pkg::div_chan_t                  chan_g,
  input  rncc_pkg::div_chan_t                  chan_b,
  output logic [rncc_pkg::IntenW-1:0]          red,
  output logic [rncc_pkg::IntenW-1:0]          green,
  output logic [rncc_pkg::IntenW-1:0]          blue,
  output rncc_pkg::color_t                     color_index
);
  import rncc_pkg::*;

  logic [2:0][IntenW-1:0] x_in;
  logic [2:0][IntenW-1:0] x_inv;   // 255 - x
  logic [2:0][IntenW-1:0] x0, x1, x2;
  logic [2:0][SqW-1:0]    sq_lo;   // squared distance to 0
  logic [2:0][SqW-1:0]    sq_hi;   // squared distance to 255
  logic [NumRefs-1:0][DistW-1:0] ref_dist;
  logic [NumRefs-1:0][DistW-1:0] ref_dist_next;
  logic [DistW-1:0] d01, d23, d4;
  color_t           i01, i23;
  logic [DistW-1:0] win_d;
  color_t           win_i;
  color_t           pick;

  assign x_in[0] = chan_intensity(chan_r);
  assign x_in[1] = chan_intensity(chan_g);
  assign x_in[2] = chan_intensity(chan_b);
  assign x_inv   = ~x_in;

  // Stage 0: per-channel squares
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int c = 0; c < 3; c++) begin
        sq_lo[c] <= x_in[c] * x_in[c];
        sq_hi[c] <= x_inv[c] * x_inv[c];
      end
      x0 <= x_in;
    end
  end

  // Stage 1: distance sums
  always_comb begin
    for (int i = 0; i < NumRefs; i++) begin
      ref_dist_next[i] = '0;
      for (int c = 0; c < 3; c++) begin
        ref_dist_next[i] = ref_dist_next[i]
                         + {2'b00, (REF_FULL[i][c] ? sq_hi[c] : sq_lo[c])};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ref_dist <= ref_dist_next;
      x1       <= x0;
    end
  end

  // Stage 2: pairwise minimum, lower index kept on a tie
  always_ff @(posedge clk) begin
    if (en[2]) begin
      if (ref_dist[1] < ref_dist[0]) begin
        d01 <= ref_dist[1];
        i01 <= COLOR_GREEN;
      end else begin
        d01 <= ref_dist[0];
        i01 <= COLOR_RED;
      end
      if (ref_dist[3] < ref_dist[2]) begin
        d23 <= ref_dist[3];
        i23 <= COLOR_WHITE;
      end else begin
        d23 <= ref_dist[2];
        i23 <= COLOR_BLUE;
      end
      d4 <= ref_dist[4];
      x2 <= x1;
    end
  end

  // Stage 3: final pick; nothing under the bound falls back to red
  always_comb begin
    win_d = d01;
    win_i = i01;
    if (d23 < win_d) begin
      win_d = d23;
      win_i = i23;
    end
    if (d4 < win_d) begin
      win_d = d4;
      win_i = COLOR_BLACK;
    end
    pick = (win_d < DIST_BOUND) ? win_i : COLOR_RED;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      red         <= x2[0];
      green       <= x2[1];
      blue        <= x2[2];
      color_index <= pick;
    end
  end

endmodule

>>> dv/tb_rgb_nearest_color_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_nearest_color_classifier_unit
// Self-checking bench for the nearest color classifier.
// ----------------------------------------------------------------------------
// A queue of pending sensor readings feeds a bursty stream driver. Every
// transfer the block takes is classified at that edge by a local model of
// the count-to-intensity map and the nearest-reference search, and the
// result is queued. A monitor behind a stalling receiver compares each output
// transfer field by field with the oldest queued result. Calibration is
// reloaded only between phases, once the stream has drained: reset values,
// a direct-map setting for tie cases, inverted and degenerate windows, and
// random windows.
// ----------------------------------------------------------------------------
module tb_rgb_nearest_color_classifier_unit;
  import rncc_pkg::*;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          MAX_REPORTS = 100;
  localparam int          TAIL_CYCLES = 20;    // pipeline is 14 deep
  localparam logic [7:0]  LEVEL_MAX   = 8'd255;
  localparam logic [23:0] COUNT_MAX   = 24'hFFFFFF;

  // Channel slots in the calibration arrays
  localparam int CH_R = 0;
  localparam int CH_G = 1;
  localparam int CH_B = 2;

  // Register indexes the block must ignore
  localparam logic [RegIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [RegIdxW-1:0] CFG_SPARE_HI = 3'd7;

  // Sender pacing
  localparam int TX_STREAM = 0;
  localparam int TX_BURSTY = 1;

  // Receiver stall patterns
  localparam int RX_ALWAYS   = 0;
  localparam int RX_RANDOM   = 1;
  localparam int RX_PERIODIC = 2;
  localparam int RX_LONG     = 3;

  typedef struct {
    logic [IntenW-1:0] red;
    logic [IntenW-1:0] green;
    logic [IntenW-1:0] blue;
    color_t            color;
  } classified_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  // raw_red[23:0], raw_green[47:24], raw_blue[71:48]
  logic [DataInW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // red[7:0], green[15:8], blue[23:16], color_index[26:24], zero fill
  logic [DataOutW-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                cfg_we = 1'b0;
  logic [RegIdxW-1:0]  cfg_index = '0;
  logic [CountW-1:0]   cfg_data = '0;

  // Readings waiting for the driver, and classifications waiting for output
  logic [DataInW-1:0] readings_to_send[$];
  classified_t        classes_due[$];

  // Local copy of the calibration registers
  logic [CountW-1:0] cal_white[3];
  logic [CountW-1:0] cal_black[3];

  int          tx_mode = TX_STREAM;
  int          rx_mode = RX_ALWAYS;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  rgb_nearest_color_classifier_unit dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------

  // White test first: a timeout count of 0 lands here, and so does an inverted
  // window's count that passes both tests. Division only happens strictly inside the window.
  function automatic logic [IntenW-1:0] count_to_level(logic [CountW-1:0] raw,
                                                       logic [CountW-1:0] white,
                                                       logic [CountW-1:0] black);
    logic [31:0] num;
    logic [31:0] span;
    if (raw <= white) return LEVEL_MAX;
    if (raw >= black) return '0;
    num  = (black - raw) * 32'd255;
    span = black - white;
    return IntenW'(num / span);
  endfunction

  function automatic int ref_component(color_t c, int ch);
    case (c)
      COLOR_RED:   return (ch == CH_R) ? 255 : 0;
      COLOR_GREEN: return (ch == CH_G) ? 255 : 0;
      COLOR_BLUE:  return (ch == CH_B) ? 255 : 0;
      COLOR_WHITE: return 255;
      default:     return 0;
    endcase
  endfunction

  function automatic classified_t classify_reading(logic [DataInW-1:0] word);
    classified_t res;
    color_t      c;
    int          dr, dg, db, dsq, best_dist;
    res.red   = count_to_level(word[23:0],  cal_white[CH_R], cal_black[CH_R]);
    res.green = count_to_level(word[47:24], cal_white[CH_G], cal_black[CH_G]);
    res.blue  = count_to_level(word[71:48], cal_white[CH_B], cal_black[CH_B]);
    // strict less-than keeps the lowest index on a tie
    res.color = COLOR_RED;
    best_dist = 100000;
    for (int i = 0; i < NumRefs; i++) begin
      c    = color_t'(i);
      dr   = int'(res.red)   - ref_component(c, CH_R);
      dg   = int'(res.green) - ref_component(c, CH_G);
      db   = int'(res.blue)  - ref_component(c, CH_B);
      dsq  = dr * dr + dg * dg + db * db;
      if (dsq < best_dist) begin
        best_dist = dsq;
        res.color = c;
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: bursts of transfers with random gaps in bursty mode; tvalid and tdata hold while
  // the block back-pressures.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : tx_side
    logic [DataInW-1:0] next_word;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        classes_due.push_back(classify_reading(s_axis_tdata));
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left != 0) begin
          s_axis_tvalid <= 1'b0;
          gap_left      <= gap_left - 1;
        end else if (readings_to_send.size() != 0) begin
          next_word     = readings_to_send.pop_front();
          s_axis_tdata  <= next_word;
          s_axis_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 40);
            if (tx_mode == TX_STREAM || $urandom_range(0, 3) == 0)
              gap_left <= 0;
            else
              gap_left <= $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and receiver stall pattern
  // --------------------------------------------------------------------------
  task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : rx_side
    classified_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (classes_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected transfer, expected none, actual %h",
                     $time, m_axis_tdata);
        end else begin
          want = classes_due.pop_front();
          check_field("red",         want.red,          m_axis_tdata[7:0]);
          check_field("green",       want.green,        m_axis_tdata[15:8]);
          check_field("blue",        want.blue,         m_axis_tdata[23:16]);
          check_field("color_index", 8'(want.color),    8'(m_axis_tdata[26:24]));
          check_field("fill",        8'd0,              8'(m_axis_tdata[31:27]));
        end
      end
      case (rx_mode)
        RX_ALWAYS:   m_axis_tready <= 1'b1;
        RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 99) < 70);
        RX_PERIODIC: m_axis_tready <= ((cycle_count % 7) >= 2);
        RX_LONG: begin
          // long stalls back the whole pipeline up into s_axis_tready
          if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
          end else if ($urandom_range(0, 9) == 0) begin
            stall_left    <= $urandom_range(1, 30);
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
          end
        end
        default: m_axis_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_reading(logic [CountW-1:0] r, logic [CountW-1:0] g,
                               logic [CountW-1:0] b);
    readings_to_send.push_back({b, g, r});
  endtask

  // Returns on a falling edge once nothing is pending or in flight.
  task automatic wait_drained;
    do @(negedge clk);
    while (readings_to_send.size() != 0 || s_axis_tvalid || classes_due.size() != 0);
  endtask

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [CountW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WHITE_RED:   cal_white[CH_R] = val;
      REG_BLACK_RED:   cal_black[CH_R] = val;
      REG_WHITE_GREEN: cal_white[CH_G] = val;
      REG_BLACK_GREEN: cal_black[CH_G] = val;
      REG_WHITE_BLUE:  cal_white[CH_B] = val;
      REG_BLACK_BLUE:  cal_black[CH_B] = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_cal(logic [CountW-1:0] wr, logic [CountW-1:0] br,
                          logic [CountW-1:0] wg, logic [CountW-1:0] bg,
                          logic [CountW-1:0] wb, logic [CountW-1:0] bb);
    write_reg(REG_WHITE_RED,   wr);
    write_reg(REG_BLACK_RED,   br);
    write_reg(REG_WHITE_GREEN, wg);
    write_reg(REG_BLACK_GREEN, bg);
    write_reg(REG_WHITE_BLUE,  wb);
    write_reg(REG_BLACK_BLUE,  bb);
  endtask

  // Mostly sane sensor windows, sometimes wide or inverted ones
  task automatic choose_window(output logic [CountW-1:0] w, output logic [CountW-1:0] b);
    case ($urandom_range(0, 5))
      0: begin
        w = CountW'($urandom);
        b = CountW'($urandom);
      end
      1: begin
        w = CountW'($urandom_range(0, 2000));
        b = w + CountW'($urandom_range(2, 4000));
      end
      default: begin
        w = CountW'($urandom_range(100, 400));
        b = w + CountW'($urandom_range(100, 900));
      end
    endcase
  endtask

  // Counts cluster inside and around the window so the divider gets work
  function automatic logic [CountW-1:0] pick_count(logic [CountW-1:0] white,
                                                   logic [CountW-1:0] black);
    logic [CountW-1:0] lo;
    logic [CountW-1:0] hi;
    lo = (white < black) ? white : black;
    hi = (white < black) ? black : white;
    case ($urandom_range(0, 7))
      0, 1: return CountW'($urandom);
      2: begin
        case ($urandom_range(0, 7))
          0:       return white;
          1:       return white + 24'd1;
          2:       return white - 24'd1;
          3:       return black;
          4:       return black - 24'd1;
          5:       return black + 24'd1;
          6:       return '0;
          default: return COUNT_MAX;
        endcase
      end
      default: return lo + CountW'($urandom_range(0, hi - lo));
    endcase
  endfunction

  initial begin : stimulus
    logic [CountW-1:0] w[3];
    logic [CountW-1:0] b[3];
    cal_white[CH_R] = WHITE_RED_RST;
    cal_black[CH_R] = BLACK_RED_RST;
    cal_white[CH_G] = WHITE_GREEN_RST;
    cal_black[CH_G] = BLACK_GREEN_RST;
    cal_white[CH_B] = WHITE_BLUE_RST;
    cal_black[CH_B] = BLACK_BLUE_RST;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset calibration: timeout, extremes, pure colors, window edges
    queue_reading('0, '0, '0);
    queue_reading(COUNT_MAX, COUNT_MAX, COUNT_MAX);
    queue_reading(24'd225, 24'd800, 24'd750);
    queue_reading(24'd600, 24'd220, 24'd750);
    queue_reading(24'd600, 24'd800, 24'd240);
    queue_reading(24'd226, 24'd221, 24'd241);
    queue_reading(24'd599, 24'd799, 24'd749);
    queue_reading(24'd224, 24'd219, 24'd239);
    queue_reading(24'd400, 24'd500, 24'd500);
    queue_reading(24'hAAAAAA, 24'h555555, 24'h123456);

    // Window 0..255 makes intensity = 255 - count, so exact ties are reachable.
    // Writes to the unused indexes must change nothing.
    wait_drained();
    tx_mode = TX_BURSTY;
    rx_mode = RX_RANDOM;
    load_cal('0, 24'd255, '0, 24'd255, '0, 24'd255);
    write_reg(CFG_SPARE_LO, COUNT_MAX);
    write_reg(CFG_SPARE_HI, 24'd1);
    queue_reading(24'd127, 24'd127, 24'd255);  // red/green tie
    queue_reading(24'd255, 24'd127, 24'd127);  // green/blue tie
    queue_reading(24'd127, 24'd255, 24'd127);  // red/blue tie
    queue_reading(24'd128, 24'd128, 24'd128);  // just black of the gray midpoint
    queue_reading(24'd127, 24'd127, 24'd127);  // just white of it
    queue_reading(24'd1, 24'd254, 24'd255);
    queue_reading(24'd256, 24'd0, 24'd1);
    queue_reading(24'hFFFFFF, 24'h0000FF, 24'h000080);
    queue_reading(24'h800000, 24'h7FFFFF, 24'h000001);

    // Random phases; the drain between phases is where the sender waits for
    // every outstanding result before touching calibration.
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      tx_mode = (p % 2 == 0) ? TX_BURSTY : TX_STREAM;
      rx_mode = (p + 1) % 4;
      case (p)
        0: begin
          // inverted, closed and widest windows
          w[CH_R] = COUNT_MAX; b[CH_R] = '0;
          w[CH_G] = 24'd1000;  b[CH_G] = 24'd1000;
          w[CH_B] = '0;        b[CH_B] = COUNT_MAX;
        end
        1: begin
          // zero-width at the bottom, divisor of two, and divisor of one at the top
          w[CH_R] = '0;            b[CH_R] = '0;
          w[CH_G] = 24'd5;         b[CH_G] = 24'd7;
          w[CH_B] = COUNT_MAX - 1; b[CH_B] = COUNT_MAX;
        end
        7: begin
          w[CH_R] = WHITE_RED_RST;   b[CH_R] = BLACK_RED_RST;
          w[CH_G] = WHITE_GREEN_RST; b[CH_G] = BLACK_GREEN_RST;
          w[CH_B] = WHITE_BLUE_RST;  b[CH_B] = BLACK_BLUE_RST;
        end
        default: begin
          for (int ch = 0; ch < 3; ch++) choose_window(w[ch], b[ch]);
        end
      endcase
      load_cal(w[CH_R], b[CH_R], w[CH_G], b[CH_G], w[CH_B], b[CH_B]);
      for (int n = 0; n < 70; n++) begin
        queue_reading(pick_count(w[CH_R], b[CH_R]), pick_count(w[CH_G], b[CH_G]),
                      pick_count(w[CH_B], b[CH_B]));
        // one extra full drain mid-phase with no calibration change
        if (p == 3 && n == 34) wait_drained();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
